// File: sv/rpnse_pkg.sv
// Package for the RPN stack evaluator: character codes, status codes,
// stack cell commands and the control structs of the multiply/divide unit.
// No dependencies.
package rpnse_pkg;

   // Defaults for the top-level parameters
   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Result field widths
   localparam int RESULT_WIDTH = 32;
   localparam int STATUS_WIDTH = 3;

   // Character codes
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_BADCHAR  = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FEW      = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_DIVZERO  = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_DEPTH    = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 3'd5;

   // Per-cycle command to every stack cell
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2
   } cell_cmd_type;

   // Control into the multiply/divide unit
   typedef struct packed {
      logic start;
      logic is_div;
      logic ack;
   } md_ctl_type;

   // Status out of the multiply/divide unit
   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

endpackage

// File: sv/rpnse_cell.sv
// One stack cell of the RPN evaluator: holds one operand and takes its
// neighbor's value on a push or a pop. Depends on rpnse_pkg.
module rpnse_cell #(
   parameter int VALUE_WIDTH = rpnse_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  rpnse_pkg::cell_cmd_type   cmd,
   input  logic [VALUE_WIDTH-1:0]    from_above,
   input  logic [VALUE_WIDTH-1:0]    from_below,
   output logic [VALUE_WIDTH-1:0]    value_q
);
   import rpnse_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   // Push moves values deeper, pop moves them toward the top
   always_comb begin
      case (cmd)
         CELL_PUSH: value_in = from_above;
         CELL_POP:  value_in = from_below;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_q = value_ff;

endmodule

// File: sv/rpnse_muldiv.sv
// Shared iterative multiply/divide unit: shift-add multiply and restoring
// signed divide, one bit per cycle. Depends on rpnse_pkg.
module rpnse_muldiv #(
   parameter int VALUE_WIDTH = rpnse_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rpnse_pkg::md_ctl_type     ctl,
   input  logic [VALUE_WIDTH-1:0]    lhs,
   input  logic [VALUE_WIDTH-1:0]    rhs,
   output rpnse_pkg::md_stat_type    stat,
   output logic [VALUE_WIDTH-1:0]    result
);
   import rpnse_pkg::*;

   localparam int CW = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   is_div_ff, is_div_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [VALUE_WIDTH-1:0] y_ff, y_in;
   logic [VALUE_WIDTH:0]   z_ff, z_in;

   logic [VALUE_WIDTH-1:0] lhs_mag;
   logic [VALUE_WIDTH-1:0] rhs_mag;
   logic [VALUE_WIDTH:0]   rem_sh;
   logic [VALUE_WIDTH:0]   divisor;

   // Operand magnitudes for the divide
   assign lhs_mag = lhs[VALUE_WIDTH-1] ? (~lhs + 1'b1) : lhs;
   assign rhs_mag = rhs[VALUE_WIDTH-1] ? (~rhs + 1'b1) : rhs;
   assign rem_sh  = {z_ff[VALUE_WIDTH-1:0], y_ff[VALUE_WIDTH-1]};
   assign divisor = {1'b0, x_ff};

   // Control: load on start, count down the bit steps, hold done until taken
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(VALUE_WIDTH - 1);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && ctl.ack) begin
         done_in = 1'b0;
      end
   end

   // Datapath: x is multiplicand or divisor, y is multiplier or quotient,
   // z is product accumulator or partial remainder
   always_comb begin
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      if (ctl.start) begin
         is_div_in = ctl.is_div;
         neg_in    = lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
         if (ctl.is_div) begin
            x_in = rhs_mag;
            y_in = lhs_mag;
         end else begin
            x_in = lhs;
            y_in = rhs;
         end
         z_in = '0;
      end else if (busy_ff) begin
         if (is_div_ff) begin
            if (rem_sh >= divisor) begin
               z_in = rem_sh - divisor;
               y_in = {y_ff[VALUE_WIDTH-2:0], 1'b1};
            end else begin
               z_in = rem_sh;
               y_in = {y_ff[VALUE_WIDTH-2:0], 1'b0};
            end
         end else begin
            if (y_ff[0]) begin
               z_in = {1'b0, z_ff[VALUE_WIDTH-1:0] + x_ff};
            end
            x_in = {x_ff[VALUE_WIDTH-2:0], 1'b0};
            y_in = {1'b0, y_ff[VALUE_WIDTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
   end

   // Apply the quotient sign; the product wraps by keeping the low bits
   always_comb begin
      if (is_div_ff) begin
         result = neg_ff ? (~y_ff + 1'b1) : y_ff;
      end else begin
         result = z_ff[VALUE_WIDTH-1:0];
      end
   end

   assign stat.busy = busy_ff | done_ff;
   assign stat.done = done_ff;

endmodule

// File: sv/rpn_stack_evaluator.sv
// RPN expression evaluator. Characters arrive one per request; digits, +, -,
// spaces, bad characters and operators that raise an error are handled as they
// are taken, while an evaluated * or / goes through a shared bit-serial
// multiply/divide unit, during which no request is taken. The operand stack
// is a row of STACK_DEPTH cells that shift down on a push and up on a pop.
// The response for an expression appears in the cycle after its last
// character completes; the block keeps taking characters of the next
// expression while that response waits, as long as the response side is not
// stalling.
// Depends on rpnse_pkg, rpnse_cell and rpnse_muldiv.
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = rpnse_pkg::STACK_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = rpnse_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_char_code,
   input  logic                                  req_last_char,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [rpnse_pkg::RESULT_WIDTH-1:0] rsp_result_value,
   output logic [rpnse_pkg::STATUS_WIDTH-1:0]    rsp_status
);
   import rpnse_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   // Control state
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [STATUS_WIDTH-1:0] err_ff, err_in;
   logic                    bad_ff, bad_in;
   logic                    pend_last_ff, pend_last_in;

   // Response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_WIDTH-1:0]        rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   is_digit, is_op, is_space, is_bad;
   logic                   is_addsub, is_muldiv;
   logic [VALUE_WIDTH-1:0] digit_value;
   logic [VALUE_WIDTH-1:0] alu_value;
   logic [VALUE_WIDTH-1:0] pop_value;
   logic [VALUE_WIDTH-1:0] top_next;
   logic                   use_md;
   logic                   finish;
   logic [STATUS_WIDTH-1:0] fin_status;
   cell_cmd_type           cell_cmd;
   md_ctl_type             md_ctl;
   md_stat_type            md_stat;
   logic [VALUE_WIDTH-1:0] md_result;
   logic [VALUE_WIDTH-1:0] cell_q [STACK_DEPTH];

   // Hold requests while the unit works or the response is stuck
   assign req_stall = md_stat.busy | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   // Decode the character
   assign is_digit  = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign is_addsub = (req_char_code == CHAR_PLUS) || (req_char_code == CHAR_MINUS);
   assign is_muldiv = (req_char_code == CHAR_STAR) || (req_char_code == CHAR_SLASH);
   assign is_op     = is_addsub | is_muldiv;
   assign is_space  = (req_char_code == CHAR_SPACE);
   assign is_bad    = ~is_digit & ~is_op & ~is_space;

   assign digit_value = VALUE_WIDTH'(req_char_code[3:0]);

   // Add or subtract: cell 1 is the left operand, cell 0 the right
   assign alu_value = (req_char_code == CHAR_PLUS) ? (cell_q[1] + cell_q[0])
                                                   : (cell_q[1] - cell_q[0]);

   // Sequence one character or a unit completion
   always_comb begin
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      bad_in       = bad_ff;
      pend_last_in = pend_last_ff;
      cell_cmd     = CELL_HOLD;
      md_ctl.start = 1'b0;
      md_ctl.is_div = (req_char_code == CHAR_SLASH);
      md_ctl.ack   = ~(pend_last_ff & rsp_valid_ff & rsp_stall);
      use_md       = 1'b0;
      finish       = 1'b0;
      if (accept) begin
         if (is_bad) begin
            bad_in = 1'b1;
         end else if (!is_space && err_ff == ST_OK) begin
            if (is_digit) begin
               if (cnt_ff == CNT_W'(STACK_DEPTH)) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  cell_cmd = CELL_PUSH;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end else if (cnt_ff < CNT_W'(2)) begin
               err_in = ST_FEW;
            end else if (is_addsub) begin
               cell_cmd = CELL_POP;
               cnt_in   = cnt_ff - 1'b1;
            end else if (req_char_code == CHAR_SLASH && cell_q[0] == '0) begin
               err_in = ST_DIVZERO;
            end else begin
               md_ctl.start = 1'b1;
            end
         end
         if (md_ctl.start) begin
            pend_last_in = req_last_char;
         end else begin
            finish = req_last_char;
         end
      end else if (md_stat.done && md_ctl.ack) begin
         use_md   = 1'b1;
         cell_cmd = CELL_POP;
         cnt_in   = cnt_ff - 1'b1;
         finish   = pend_last_ff;
      end
   end

   assign pop_value = use_md ? md_result : alu_value;

   // Top of stack after this cycle
   always_comb begin
      case (cell_cmd)
         CELL_PUSH: top_next = digit_value;
         CELL_POP:  top_next = pop_value;
         default:   top_next = cell_q[0];
      endcase
   end

   // Rank the errors for the response
   always_comb begin
      if (bad_in) begin
         fin_status = ST_BADCHAR;
      end else if (err_in != ST_OK) begin
         fin_status = err_in;
      end else if (cnt_in != CNT_W'(1)) begin
         fin_status = ST_DEPTH;
      end else begin
         fin_status = ST_OK;
      end
   end

   // Load the response on the final character, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_value_in  = (fin_status == ST_OK) ? RESULT_WIDTH'(signed'(top_next))
                                               : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         err_ff       <= ST_OK;
         bad_ff       <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Clear the expression state after its response
         if (finish) begin
            cnt_ff <= '0;
            err_ff <= ST_OK;
            bad_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_in;
            err_ff <= err_in;
            bad_ff <= bad_in;
         end
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Row of stack cells; cell 0 is the top
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] above;
      logic [VALUE_WIDTH-1:0] below;
      if (i == 0) begin : g_top
         assign above = digit_value;
         assign below = pop_value;
      end else if (i == STACK_DEPTH - 1) begin : g_bottom
         assign above = cell_q[i-1];
         assign below = cell_q[i];
      end else begin : g_mid
         assign above = cell_q[i-1];
         assign below = cell_q[i+1];
      end
      rpnse_cell #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .from_above (above),
         .from_below (below),
         .value_q    (cell_q[i])
      );
   end

   // Shared multiply/divide unit
   rpnse_muldiv #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (md_ctl),
      .lhs    (cell_q[1]),
      .rhs    (cell_q[0]),
      .stat   (md_stat),
      .result (md_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
